// File: hdl/psrf_pkg.sv
// Shared types, constants and helpers of the printable string run finder.
// Used by psrf_front, psrf_queue, psrf_back and printable_string_run_finder_core.
// Depends on nothing.
package psrf_pkg;

    // Width of the running byte position (16..64).
    localparam int OFFSET_BITS = 32;
    localparam int OUT_OFF_W   = 32;
    localparam int COUNT_W     = 32;
    localparam int MINLEN_W    = 16;

    localparam logic [MINLEN_W-1:0] MIN_LEN_RESET = MINLEN_W'(4);
    localparam logic [COUNT_W-1:0]  COUNT_MAX     = '1;

    localparam logic [7:0] CHAR_LO = 8'h20;
    localparam logic [7:0] CHAR_HI = 8'h7E;
    localparam logic [7:0] NUL     = 8'h00;

    // Step records held between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Tracker slots, in emission order.
    localparam int NUM_TRACK   = 3;
    localparam int SLOT_ASCII  = 0;
    localparam int SLOT_UTF16  = 1;
    localparam int SLOT_UTF32  = 2;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_CSTR  = 2'd1,
        KIND_UTF16 = 2'd2,
        KIND_UTF32 = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [COUNT_W-1:0]   length;
        logic [OUT_OFF_W-1:0] start;
    } t_result;

    // All results one input byte causes; hit marks the slots that carry one.
    typedef struct packed {
        logic [NUM_TRACK-1:0]  hit;
        t_result [NUM_TRACK-1:0] res;
    } t_step;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic is_print(input logic [7:0] b);
        return (b >= CHAR_LO) && (b <= CHAR_HI);
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

    function automatic logic [OUT_OFF_W-1:0] to_out_offset(input logic [OFFSET_BITS-1:0] p);
        logic [63:0] wide;
        wide = 64'(p);
        return wide[OUT_OFF_W-1:0];
    endfunction

endpackage

// File: hdl/psrf_front.sv
// Front end: accepts bytes, runs the three run trackers, builds one step record.
// Holds the min_length register. Depends on psrf_pkg.
module psrf_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  logic [7:0]               i_byte,
    input  logic                     i_eod,
    input  logic                     i_cfg_we,
    input  logic [psrf_pkg::MINLEN_W-1:0] i_cfg_data,
    output logic                     o_push,
    output psrf_pkg::t_step          o_step
);
    import psrf_pkg::*;

    logic [MINLEN_W-1:0]    r_min_len;
    logic [OFFSET_BITS-1:0] r_pos,      n_pos;
    logic [23:0]            r_recent,   n_recent;
    logic                   r_a_active, n_a_active;
    logic [OFFSET_BITS-1:0] r_a_start,  n_a_start;
    logic [COUNT_W-1:0]     r_a_count,  n_a_count;
    logic                   r_w_active, n_w_active;
    logic [OFFSET_BITS-1:0] r_w_start,  n_w_start;
    logic [COUNT_W-1:0]     r_w_count,  n_w_count;
    logic                   r_w_phase,  n_w_phase;
    logic                   r_q_active, n_q_active;
    logic [OFFSET_BITS-1:0] r_q_start,  n_q_start;
    logic [COUNT_W-1:0]     r_q_count,  n_q_count;
    logic [1:0]             r_q_phase,  n_q_phase;

    logic [7:0] b1, b2, b3;
    logic       ok16, ok32;
    t_step      step;

    function automatic logic long_enough(input logic [COUNT_W-1:0] c,
                                         input logic [MINLEN_W-1:0] m);
        return c >= COUNT_W'(m);
    endfunction

    always_comb begin
        b1   = r_recent[7:0];
        b2   = r_recent[15:8];
        b3   = r_recent[23:16];
        ok16 = is_print(b1) && (i_byte == NUL);
        ok32 = is_print(b3) && (b2 == NUL) && (b1 == NUL) && (i_byte == NUL);

        n_a_active = r_a_active; n_a_start = r_a_start; n_a_count = r_a_count;
        n_w_active = r_w_active; n_w_start = r_w_start; n_w_count = r_w_count;
        n_w_phase  = r_w_phase;
        n_q_active = r_q_active; n_q_start = r_q_start; n_q_count = r_q_count;
        n_q_phase  = r_q_phase;
        step       = '0;

        // single-byte tracker
        if (is_print(i_byte)) begin
            if (r_a_active) begin
                n_a_count = sat_inc(r_a_count);
            end else begin
                n_a_active = 1'b1;
                n_a_start  = r_pos;
                n_a_count  = COUNT_W'(1);
            end
        end else if (r_a_active) begin
            step.hit[SLOT_ASCII]        = long_enough(r_a_count, r_min_len);
            step.res[SLOT_ASCII].start  = to_out_offset(r_a_start);
            step.res[SLOT_ASCII].length = r_a_count;
            step.res[SLOT_ASCII].kind   = (i_byte == NUL) ? KIND_CSTR : KIND_PLAIN;
            n_a_active = 1'b0;
        end
        if (i_eod && n_a_active) begin
            step.hit[SLOT_ASCII]        = long_enough(n_a_count, r_min_len);
            step.res[SLOT_ASCII].start  = to_out_offset(n_a_start);
            step.res[SLOT_ASCII].length = n_a_count;
            step.res[SLOT_ASCII].kind   = KIND_PLAIN;
            n_a_active = 1'b0;
        end

        // UTF-16LE tracker: judge on the byte that completes a unit
        if (r_w_active) begin
            if (!r_w_phase) begin
                n_w_phase = 1'b1;
            end else if (ok16) begin
                n_w_count = sat_inc(r_w_count);
                n_w_phase = 1'b0;
            end else begin
                step.hit[SLOT_UTF16]        = long_enough(r_w_count, r_min_len);
                step.res[SLOT_UTF16].start  = to_out_offset(r_w_start);
                step.res[SLOT_UTF16].length = r_w_count;
                n_w_active = 1'b0;
                n_w_phase  = 1'b0;
            end
        end else if (ok16) begin
            n_w_active = 1'b1;
            n_w_start  = r_pos - OFFSET_BITS'(1);
            n_w_count  = COUNT_W'(1);
            n_w_phase  = 1'b0;
        end
        if (i_eod && n_w_active) begin
            step.hit[SLOT_UTF16]        = long_enough(n_w_count, r_min_len);
            step.res[SLOT_UTF16].start  = to_out_offset(n_w_start);
            step.res[SLOT_UTF16].length = n_w_count;
            n_w_active = 1'b0;
        end
        step.res[SLOT_UTF16].kind = KIND_UTF16;

        // UTF-32LE tracker
        if (r_q_active) begin
            if (r_q_phase != 2'd3) begin
                n_q_phase = r_q_phase + 2'd1;
            end else if (ok32) begin
                n_q_count = sat_inc(r_q_count);
                n_q_phase = 2'd0;
            end else begin
                step.hit[SLOT_UTF32]        = long_enough(r_q_count, r_min_len);
                step.res[SLOT_UTF32].start  = to_out_offset(r_q_start);
                step.res[SLOT_UTF32].length = r_q_count;
                n_q_active = 1'b0;
                n_q_phase  = 2'd0;
            end
        end else if (ok32) begin
            n_q_active = 1'b1;
            n_q_start  = r_pos - OFFSET_BITS'(3);
            n_q_count  = COUNT_W'(1);
            n_q_phase  = 2'd0;
        end
        if (i_eod && n_q_active) begin
            step.hit[SLOT_UTF32]        = long_enough(n_q_count, r_min_len);
            step.res[SLOT_UTF32].start  = to_out_offset(n_q_start);
            step.res[SLOT_UTF32].length = n_q_count;
            n_q_active = 1'b0;
        end
        step.res[SLOT_UTF32].kind = KIND_UTF32;

        // end of data restarts the offset and forgets history
        if (i_eod) begin
            n_pos     = '0;
            n_recent  = '0;
            n_w_phase = 1'b0;
            n_q_phase = 2'd0;
        end else begin
            n_pos     = r_pos + OFFSET_BITS'(1);
            n_recent  = {r_recent[15:0], i_byte};
        end
    end

    assign o_push = i_fire && (|step.hit);
    assign o_step = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len  <= MIN_LEN_RESET;
            r_pos      <= '0;
            r_recent   <= '0;
            r_a_active <= 1'b0;
            r_a_start  <= '0;
            r_a_count  <= '0;
            r_w_active <= 1'b0;
            r_w_start  <= '0;
            r_w_count  <= '0;
            r_w_phase  <= 1'b0;
            r_q_active <= 1'b0;
            r_q_start  <= '0;
            r_q_count  <= '0;
            r_q_phase  <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_min_len <= i_cfg_data;
            end
            if (i_fire) begin
                r_pos      <= n_pos;
                r_recent   <= n_recent;
                r_a_active <= n_a_active;
                r_a_start  <= n_a_start;
                r_a_count  <= n_a_count;
                r_w_active <= n_w_active;
                r_w_start  <= n_w_start;
                r_w_count  <= n_w_count;
                r_w_phase  <= n_w_phase;
                r_q_active <= n_q_active;
                r_q_start  <= n_q_start;
                r_q_count  <= n_q_count;
                r_q_phase  <= n_q_phase;
            end
        end
    end

endmodule

// File: hdl/psrf_queue.sv
// Short FIFO of step records between the front and back ends.
// Depends on psrf_pkg.
module psrf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  psrf_pkg::t_step      i_step,
    input  logic                 i_pop,
    output psrf_pkg::t_step      o_head,
    output psrf_pkg::t_q_status  o_status
);
    import psrf_pkg::*;

    t_step             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == QCNT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// File: hdl/psrf_back.sv
// Back end: drains step records one result per beat into the output register.
// Depends on psrf_pkg.
module psrf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psrf_pkg::t_step      i_head,
    input  psrf_pkg::t_q_status  i_status,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output psrf_pkg::t_result    o_result,
    output logic                 o_last
);
    import psrf_pkg::*;

    logic                 r_valid;
    t_result              r_result;
    logic                 r_last;
    logic [NUM_TRACK-1:0] r_served;

    logic [NUM_TRACK-1:0] remain;
    logic [NUM_TRACK-1:0] sel;
    logic                 more;
    logic                 load;
    t_result              pick;

    always_comb begin
        remain = i_head.hit & ~r_served;
        // lowest pending slot goes first
        sel    = remain & (~remain + NUM_TRACK'(1));
        more   = |(remain & ~sel);
        pick   = '0;
        for (int i = 0; i < NUM_TRACK; i++) begin
            if (sel[i]) begin
                pick = i_head.res[i];
            end
        end
        load   = !i_status.empty && (!r_valid || i_ready);
    end

    assign o_pop    = load && !more;
    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= pick;
            r_last   <= !more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_served <= '0;
        end else begin
            if (load) begin
                r_valid  <= 1'b1;
                r_served <= more ? (r_served | sel) : '0;
            end else if (i_ready) begin
                r_valid  <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/printable_string_run_finder_core.sv
// Printable string run finder, top level: stream ports, front/queue/back wiring.
// Depends on psrf_pkg, psrf_front, psrf_queue and psrf_back.
//
// Scans a byte stream at one byte per clock and reports runs of printable
// ASCII (0x20..0x7E) found as plain bytes, as UTF-16LE units (char, 00) and
// as UTF-32LE units (char, 00, 00, 00). Each input beat carries one byte in
// tdata and the end-of-data mark in tlast; after a beat with tlast every open
// run closes and the byte offset restarts at zero. A run of at least
// min_length characters comes out as one beat with its start offset, length
// (saturating at 2^32-1) and kind; tlast marks the final result caused by a
// given input byte, and results of one byte leave in the order ASCII, UTF-16,
// UTF-32. A plain run that ends on a 0x00 byte is tagged NUL-terminated.
// Input bytes are taken at one per cycle; the output drains one result per
// cycle while m_axis tready is high, one beat per run that a byte closes. A
// four-entry queue of per-byte records sits between the trackers and the
// output register and absorbs bursts: input ready drops only when that
// queue is full. min_length resets to 4 and is written on the config
// channel, which is always ready; write it only while the block is idle.
module printable_string_run_finder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // end_of_data
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [31:0] start_offset, [63:32] run_length,
                                          // [65:64] run_kind, [71:66] zero
    output logic        o_m_axis_tlast,   // last_of_step
    // min_length write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [psrf_pkg::MINLEN_W-1:0] i_cfg_data
);
    import psrf_pkg::*;

    logic      s_fire;
    logic      push;
    logic      pop;
    t_step     front_step;
    t_step     head;
    t_q_status q_stat;
    t_result   result;

    // accept a byte whenever the queue has room for its record
    assign o_s_axis_tready = !q_stat.full;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    psrf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s_fire),
        .i_byte     (i_s_axis_tdata),
        .i_eod      (i_s_axis_tlast),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_step     (front_step)
    );

    psrf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_step   (front_step),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_stat)
    );

    psrf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_status (q_stat),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result),
        .o_last   (o_m_axis_tlast)
    );

    // pack result fields, lowest field first
    assign o_m_axis_tdata = {6'b0, result.kind, result.length, result.start};

`ifndef NO_ASSERTIONS
    // a record is never written into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("record pushed into full queue");

    // an empty queue cannot be popped
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // a new result appears only after a queued record was available
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!q_stat.empty))
        else $error("result appeared without a queued record");

    // every reported run has at least one character
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (result.length != '0))
        else $error("zero-length run reported");
`endif

endmodule
